// ===== hdl/ttce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_pkg
// Shared types and codes for the character terminal engine.
// ----------------------------------------------------------------------------
package ttce_pkg;

    localparam logic [7:0] CH_HOME    = 8'h01;
    localparam logic [7:0] CH_CUR_ON  = 8'h02;
    localparam logic [7:0] CH_CUR_OFF = 8'h03;
    localparam logic [7:0] CH_BELL    = 8'h07;
    localparam logic [7:0] CH_BELL_HI = 8'h87;
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_CLR_EOS = 8'h14;
    localparam logic [7:0] CH_RIGHT   = 8'h15;
    localparam logic [7:0] CH_CLR_EOL = 8'h16;
    localparam logic [7:0] CH_INS_LN  = 8'h17;
    localparam logic [7:0] CH_CLR_LN  = 8'h18;
    localparam logic [7:0] CH_DEL_LN  = 8'h19;
    localparam logic [7:0] CH_UP      = 8'h1A;
    localparam logic [7:0] CH_UP_ALT  = 8'h1C;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_Y       = 8'h59;
    localparam logic [7:0] CH_BIAS    = 8'h20;
    localparam logic [6:0] BLANK      = 7'h20;

    // classified operations passed from front to back
    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_READ   = 4'd1;
    localparam logic [3:0] OP_HOME   = 4'd2;
    localparam logic [3:0] OP_CON    = 4'd3;
    localparam logic [3:0] OP_COFF   = 4'd4;
    localparam logic [3:0] OP_BELL   = 4'd5;
    localparam logic [3:0] OP_BS     = 4'd6;
    localparam logic [3:0] OP_LF     = 4'd7;
    localparam logic [3:0] OP_FF     = 4'd8;
    localparam logic [3:0] OP_CR     = 4'd9;
    localparam logic [3:0] OP_CLREOS = 4'd10;
    localparam logic [3:0] OP_RIGHT  = 4'd11;
    localparam logic [3:0] OP_CLREOL = 4'd12;
    localparam logic [3:0] OP_INSLN  = 4'd13;
    localparam logic [3:0] OP_CLRLN  = 4'd14;
    localparam logic [3:0] OP_DELLN  = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic       is_up;
        logic       is_store;
        logic       is_rub;
        logic       is_goto;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
    } t_cmd;

endpackage
`default_nettype wire

// ===== hdl/ttce_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_ram
// Single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttce_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 1920
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/ttce_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_front
// Accepts requests, tracks the escape sequence and classifies each byte.
// Holds a two-entry queue of classified commands for the back end.
// ----------------------------------------------------------------------------
module ttce_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire                 i_opcode,
    input  wire  [7:0]          i_char_code,
    input  wire  [4:0]          i_read_row,
    input  wire  [6:0]          i_read_col,
    output logic                o_cmd_valid,
    input  wire                 i_cmd_take,
    output ttce_pkg::t_cmd      o_cmd
);
    ttce_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic [1:0] r_esc;
    logic [7:0] r_row_hold;
    logic [1:0] n_esc;
    logic [7:0] n_row_hold;
    ttce_pkg::t_cmd c;
    logic acc;
    logic push;

    assign o_stall = (r_cnt == 2'd2);
    assign acc = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd = r_q[r_rd];

    always_comb begin
        c = '0;
        c.op = ttce_pkg::OP_NONE;
        n_esc = r_esc;
        n_row_hold = r_row_hold;
        if (i_opcode) begin
            c.op = ttce_pkg::OP_READ;
            c.arg_a = {3'd0, i_read_row};
            c.arg_b = {1'b0, i_read_col};
        end else if (r_esc == 2'd1) begin
            n_esc = (i_char_code == ttce_pkg::CH_EQ || i_char_code == ttce_pkg::CH_Y)
                    ? 2'd2 : 2'd0;
        end else if (r_esc == 2'd2) begin
            n_row_hold = i_char_code - ttce_pkg::CH_BIAS;
            n_esc = 2'd3;
        end else if (r_esc == 2'd3) begin
            c.is_goto = 1'b1;
            c.arg_a = r_row_hold;
            c.arg_b = i_char_code - ttce_pkg::CH_BIAS;
            n_esc = 2'd0;
        end else begin
            c.arg_a = i_char_code;
            unique case (i_char_code) inside
                ttce_pkg::CH_HOME:    c.op = ttce_pkg::OP_HOME;
                ttce_pkg::CH_CUR_ON:  c.op = ttce_pkg::OP_CON;
                ttce_pkg::CH_CUR_OFF: c.op = ttce_pkg::OP_COFF;
                ttce_pkg::CH_BELL, ttce_pkg::CH_BELL_HI: c.op = ttce_pkg::OP_BELL;
                ttce_pkg::CH_BS:      c.op = ttce_pkg::OP_BS;
                ttce_pkg::CH_LF:      c.op = ttce_pkg::OP_LF;
                ttce_pkg::CH_FF:      c.op = ttce_pkg::OP_FF;
                ttce_pkg::CH_CR:      c.op = ttce_pkg::OP_CR;
                ttce_pkg::CH_CLR_EOS: c.op = ttce_pkg::OP_CLREOS;
                ttce_pkg::CH_RIGHT:   c.op = ttce_pkg::OP_RIGHT;
                ttce_pkg::CH_CLR_EOL: c.op = ttce_pkg::OP_CLREOL;
                ttce_pkg::CH_INS_LN:  c.op = ttce_pkg::OP_INSLN;
                ttce_pkg::CH_CLR_LN:  c.op = ttce_pkg::OP_CLRLN;
                ttce_pkg::CH_DEL_LN:  c.op = ttce_pkg::OP_DELLN;
                ttce_pkg::CH_UP, ttce_pkg::CH_UP_ALT: c.is_up = 1'b1;
                ttce_pkg::CH_ESC:     n_esc = 2'd1;
                ttce_pkg::CH_DEL:     c.is_rub = 1'b1;
                default: begin
                    if ((i_char_code >= 8'h20 && i_char_code < 8'h7F) ||
                        (i_char_code >= 8'h84 && i_char_code <= 8'h86)) begin
                        c.is_store = 1'b1;
                    end
                end
            endcase
        end
    end

    // every accepted request yields exactly one command
    assign push = acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd <= 1'b0;
            r_esc <= 2'd0;
            r_row_hold <= 8'd0;
        end else begin
            if (acc) begin
                r_esc <= n_esc;
                r_row_hold <= n_row_hold;
            end
            if (push) begin
                r_q[r_rd ^ r_cnt[0]] <= c;
            end
            if (i_cmd_take) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_cmd_take};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/ttce_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttce_back
// Executes commands on the cursor and screen RAM; runs cell sweeps for
// clears and line moves, and the clearing pass after reset.
// ----------------------------------------------------------------------------
module ttce_back #(
    parameter int ROW_COUNT = 24,
    parameter int COL_COUNT = 80
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cmd_valid,
    output logic                o_cmd_take,
    input  ttce_pkg::t_cmd      i_cmd,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic [6:0]          o_cell_data,
    output logic [4:0]          o_cursor_row,
    output logic [6:0]          o_cursor_col,
    output logic                o_cursor_shown,
    output logic                o_bell_pulse
);
    localparam int CELLS = ROW_COUNT * COL_COUNT;
    localparam int AW = $clog2(CELLS);
    localparam int RW = $clog2(ROW_COUNT);
    localparam int CW = $clog2(COL_COUNT);
    localparam logic [AW-1:0] LAST = AW'(CELLS - 1);
    localparam logic [AW-1:0] NCOL = AW'(COL_COUNT);
    localparam logic [6:0] BLANK_C = ttce_pkg::BLANK;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_FILL = 3'd2;
    localparam logic [2:0] S_MRD  = 3'd3;
    localparam logic [2:0] S_MWR  = 3'd4;
    localparam logic [2:0] S_RD   = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]    r_st;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic          r_on;
    logic          r_bell;
    logic [6:0]    r_cell;
    logic          r_ovalid;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_end;
    logic          r_dn;      // move direction: 1 = copy from above (insert)
    logic [AW-1:0] r_fill_to; // last cell to blank, after a move or for a clear
    logic          r_rd_ok;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [6:0]    wdata, rdata;

    logic [AW-1:0] lin, rstart;

    ttce_ram #(.WIDTH(7), .DEPTH(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rstart = AW'(r_row) * NCOL;
    assign lin = rstart + AW'(r_col);
    assign o_valid = r_ovalid;
    assign o_cell_data = r_cell;
    assign o_cursor_row = 5'(r_row);
    assign o_cursor_col = 7'(r_col);
    assign o_cursor_shown = r_on;
    assign o_bell_pulse = r_bell;
    assign o_cmd_take = (r_st == S_IDLE) && i_cmd_valid && !r_ovalid;

    always_comb begin
        we = 1'b0;
        waddr = r_ptr;
        wdata = BLANK_C;
        raddr = r_dn ? r_ptr - NCOL : r_ptr + NCOL;
        if (r_st == S_INIT || r_st == S_FILL) begin
            we = 1'b1;
        end else if (r_st == S_MWR) begin
            we = 1'b1;
            wdata = rdata;
        end else if (r_st == S_RD) begin
            raddr = r_ptr;
        end else if (o_cmd_take && (i_cmd.is_store || i_cmd.is_rub)) begin
            we = 1'b1;
            waddr = lin;
            wdata = i_cmd.is_store ? i_cmd.arg_a[6:0] : BLANK_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_ptr <= '0;
            r_row <= '0;
            r_col <= '0;
            r_on <= 1'b1;
            r_ovalid <= 1'b0;
            r_bell <= 1'b0;
            r_cell <= '0;
            r_dn <= 1'b0;
            r_end <= '0;
            r_fill_to <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_INIT: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == LAST) begin
                        r_st <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_bell <= 1'b0;
                        r_cell <= '0;
                        r_st <= S_OUT;
                        if (i_cmd.is_goto) begin
                            r_row <= (i_cmd.arg_a >= 8'(ROW_COUNT)) ?
                                     RW'(ROW_COUNT - 1) : RW'(i_cmd.arg_a);
                            r_col <= (i_cmd.arg_b >= 8'(COL_COUNT)) ?
                                     CW'(COL_COUNT - 1) : CW'(i_cmd.arg_b);
                        end else if (i_cmd.is_up) begin
                            if (r_row != '0) r_row <= r_row - 1'b1;
                        end else if (i_cmd.is_store) begin
                            if (r_col != CW'(COL_COUNT - 1)) begin
                                r_col <= r_col + 1'b1;
                            end else begin
                                r_col <= '0;
                                if (r_row != RW'(ROW_COUNT - 1)) begin
                                    r_row <= r_row + 1'b1;
                                end else begin
                                    r_dn <= 1'b0;
                                    r_ptr <= '0;
                                    r_end <= LAST - NCOL;
                                    r_fill_to <= LAST;
                                    r_st <= S_MRD;
                                end
                            end
                        end else if (!i_cmd.is_rub) begin
                            case (i_cmd.op)
                                ttce_pkg::OP_READ: begin
                                    r_rd_ok <= (i_cmd.arg_a < 8'(ROW_COUNT)) &&
                                               (i_cmd.arg_b < 8'(COL_COUNT));
                                    r_ptr <= AW'(i_cmd.arg_a[4:0]) * NCOL +
                                             AW'(i_cmd.arg_b[6:0]);
                                    r_st <= S_RD;
                                end
                                ttce_pkg::OP_HOME: begin
                                    r_row <= '0;
                                    r_col <= '0;
                                end
                                ttce_pkg::OP_CON: r_on <= 1'b1;
                                ttce_pkg::OP_COFF: r_on <= 1'b0;
                                ttce_pkg::OP_BELL: r_bell <= 1'b1;
                                ttce_pkg::OP_BS: begin
                                    if (r_col != '0) begin
                                        r_col <= r_col - 1'b1;
                                    end else if (r_row != '0) begin
                                        r_row <= r_row - 1'b1;
                                        r_col <= CW'(COL_COUNT - 1);
                                    end
                                end
                                ttce_pkg::OP_LF: begin
                                    if (r_row != RW'(ROW_COUNT - 1)) begin
                                        r_row <= r_row + 1'b1;
                                    end else begin
                                        r_dn <= 1'b0;
                                        r_ptr <= '0;
                                        r_end <= LAST - NCOL;
                                        r_fill_to <= LAST;
                                        r_st <= S_MRD;
                                    end
                                end
                                ttce_pkg::OP_FF: begin
                                    r_row <= '0;
                                    r_col <= '0;
                                    r_ptr <= '0;
                                    r_fill_to <= LAST;
                                    r_st <= S_FILL;
                                end
                                ttce_pkg::OP_CR: r_col <= '0;
                                ttce_pkg::OP_CLREOS: begin
                                    r_ptr <= lin;
                                    r_fill_to <= LAST;
                                    r_st <= S_FILL;
                                end
                                ttce_pkg::OP_RIGHT: begin
                                    if (r_col != CW'(COL_COUNT - 1)) begin
                                        r_col <= r_col + 1'b1;
                                    end else if (r_row != RW'(ROW_COUNT - 1)) begin
                                        r_col <= '0;
                                        r_row <= r_row + 1'b1;
                                    end
                                end
                                ttce_pkg::OP_CLREOL: begin
                                    r_ptr <= lin;
                                    r_fill_to <= rstart + NCOL - 1'b1;
                                    r_st <= S_FILL;
                                end
                                ttce_pkg::OP_CLRLN: begin
                                    r_col <= '0;
                                    r_ptr <= rstart;
                                    r_fill_to <= rstart + NCOL - 1'b1;
                                    r_st <= S_FILL;
                                end
                                ttce_pkg::OP_INSLN: begin
                                    r_fill_to <= rstart + NCOL - 1'b1;
                                    if (r_row == RW'(ROW_COUNT - 1)) begin
                                        r_ptr <= rstart;
                                        r_st <= S_FILL;
                                    end else begin
                                        r_dn <= 1'b1;
                                        r_ptr <= LAST;
                                        r_end <= rstart + NCOL;
                                        r_st <= S_MRD;
                                    end
                                end
                                ttce_pkg::OP_DELLN: begin
                                    r_fill_to <= LAST;
                                    if (r_row == RW'(ROW_COUNT - 1)) begin
                                        r_ptr <= rstart;
                                        r_st <= S_FILL;
                                    end else begin
                                        r_dn <= 1'b0;
                                        r_ptr <= rstart;
                                        r_end <= LAST - NCOL;
                                        r_st <= S_MRD;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                S_MRD: r_st <= S_MWR;
                S_MWR: begin
                    if (r_ptr == r_end) begin
                        if (r_dn) begin
                            r_ptr <= r_fill_to - NCOL + 1'b1;
                        end else begin
                            r_ptr <= LAST - NCOL + 1'b1;
                        end
                        r_st <= S_FILL;
                    end else begin
                        r_ptr <= r_dn ? r_ptr - 1'b1 : r_ptr + 1'b1;
                        r_st <= S_MRD;
                    end
                end
                S_FILL: begin
                    r_ptr <= r_ptr + 1'b1;
                    if (r_ptr == r_fill_to) begin
                        r_st <= S_OUT;
                    end
                end
                S_RD: r_st <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_OUT && r_rd_ok) begin
                r_cell <= rdata;
                r_rd_ok <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/text_terminal_char_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_terminal_char_engine
// Character-cell terminal: cursor, escape addressing and screen store.
// ----------------------------------------------------------------------------
// channel | dir | handshake        | payload
// input   | in  | i_valid/o_stall  | opcode, char_code, read_row, read_col
// output  | out | o_valid/i_stall  | cell_data, cursor_row/col, shown, bell
// Clears walk the screen RAM one cell a cycle; line moves and scroll copy each cell
// with a read then a write. After reset a clearing pass over all ROWS*COLS cells
// runs before any request is executed. Requests queue two deep in front while
// the back end is busy.
// ----------------------------------------------------------------------------
module text_terminal_char_engine #(
    parameter int ROW_COUNT = 24,
    parameter int COL_COUNT = 80
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire         i_opcode,
    input  wire  [7:0]  i_char_code,
    input  wire  [4:0]  i_read_row,
    input  wire  [6:0]  i_read_col,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [6:0]  o_cell_data,
    output logic [4:0]  o_cursor_row,
    output logic [6:0]  o_cursor_col,
    output logic        o_cursor_shown,
    output logic        o_bell_pulse
);
    logic           cmd_valid;
    logic           cmd_take;
    ttce_pkg::t_cmd cmd;

    ttce_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_opcode(i_opcode), .i_char_code(i_char_code),
        .i_read_row(i_read_row), .i_read_col(i_read_col),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    ttce_back #(.ROW_COUNT(ROW_COUNT), .COL_COUNT(COL_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_take(cmd_take), .i_cmd(cmd), .o_valid(o_valid), .i_stall(i_stall),
        .o_cell_data(o_cell_data), .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col), .o_cursor_shown(o_cursor_shown),
        .o_bell_pulse(o_bell_pulse)
    );

    a_cmd_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid) else $error("command taken from empty queue");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_row < 5'(ROW_COUNT))) else $error("row out of range");
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_col < 7'(COL_COUNT))) else $error("col out of range");
    a_bell_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bell_pulse) |-> (o_cell_data == 7'd0))
        else $error("bell with cell data");
endmodule
`default_nettype wire

// ===== bench/text_terminal_char_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_terminal_char_engine_test
// Self-checking bench for the character terminal engine: directed control
// codes and escape addressing, then random text, controls and cell reads
// under several stall patterns, checked against a behavioral screen model.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_test;

    localparam int ROWS  = 24;
    localparam int COLS  = 80;
    localparam int CELLS = ROWS * COLS;
    localparam int WATCHDOG_LIMIT = 200000;

    typedef struct packed {
        logic [6:0] data;
        logic [4:0] row;
        logic [6:0] col;
        logic       shown;
        logic       bell;
    } t_status;

    class terminal_scoreboard;
        logic [6:0] screen[CELLS];
        int         cur;
        bit         shown;
        int         esc;
        logic [7:0] row_hold;
        t_status    pending[$];
        int         errors;

        function new();
            foreach (screen[i]) screen[i] = ttce_pkg::BLANK;
            cur = 0; shown = 1; esc = 0; row_hold = 0; errors = 0;
        endfunction

        function void blank(int from, int upto);
            for (int i = from; i < upto && i < CELLS; i++) screen[i] = ttce_pkg::BLANK;
        endfunction

        function void scroll();
            for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            blank(CELLS - COLS, CELLS);
        endfunction

        function bit put_char(logic [7:0] ch);
            int rs;
            int r;
            int c;
            rs = (cur / COLS) * COLS;
            if (esc == 1) begin
                esc = (ch == ttce_pkg::CH_EQ || ch == ttce_pkg::CH_Y) ? 2 : 0;
                return 0;
            end
            if (esc == 2) begin
                row_hold = ch - ttce_pkg::CH_BIAS;
                esc = 3;
                return 0;
            end
            if (esc == 3) begin
                r = row_hold;
                c = 8'(ch - ttce_pkg::CH_BIAS);
                if (r >= ROWS) r = ROWS - 1;
                if (c >= COLS) c = COLS - 1;
                cur = r * COLS + c;
                esc = 0;
                return 0;
            end
            case (ch) inside
                ttce_pkg::CH_HOME: cur = 0;
                ttce_pkg::CH_CUR_ON: shown = 1;
                ttce_pkg::CH_CUR_OFF: shown = 0;
                ttce_pkg::CH_BELL, ttce_pkg::CH_BELL_HI: return 1;
                ttce_pkg::CH_BS: if (cur > 0) cur--;
                ttce_pkg::CH_LF: begin
                    if (rs + COLS >= CELLS) scroll();
                    else cur += COLS;
                end
                ttce_pkg::CH_FF: begin
                    blank(0, CELLS);
                    cur = 0;
                end
                ttce_pkg::CH_CR: cur = rs;
                ttce_pkg::CH_CLR_EOS: blank(cur, CELLS);
                ttce_pkg::CH_RIGHT: if (cur + 1 < CELLS) cur++;
                ttce_pkg::CH_CLR_EOL: blank(cur, rs + COLS);
                ttce_pkg::CH_INS_LN: begin
                    for (int i = CELLS - 1; i >= rs + COLS; i--) screen[i] = screen[i - COLS];
                    blank(rs, rs + COLS);
                end
                ttce_pkg::CH_CLR_LN: begin
                    blank(rs, rs + COLS);
                    cur = rs;
                end
                ttce_pkg::CH_DEL_LN: begin
                    for (int i = rs; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
                    blank(CELLS - COLS, CELLS);
                end
                ttce_pkg::CH_UP, ttce_pkg::CH_UP_ALT: if (cur >= COLS) cur -= COLS;
                ttce_pkg::CH_ESC: esc = 1;
                ttce_pkg::CH_DEL: screen[cur] = ttce_pkg::BLANK;
                default: begin
                    if ((ch >= 8'h20 && ch < 8'h7F) || (ch >= 8'h84 && ch <= 8'h86)) begin
                        screen[cur] = ch[6:0];
                        cur++;
                        if (cur >= CELLS) begin
                            cur -= COLS;
                            scroll();
                        end
                    end
                end
            endcase
            return 0;
        endfunction

        function void note_request(bit op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
            t_status s;
            s.data = '0;
            s.bell = 0;
            if (op) begin
                if (rr < ROWS && rc < COLS) s.data = screen[rr * COLS + rc];
            end else begin
                s.bell = put_char(ch);
            end
            s.row = 5'(cur / COLS);
            s.col = 7'(cur % COLS);
            s.shown = shown;
            pending.push_back(s);
        endfunction

        function void check_result(t_status got);
            t_status e;
            if (pending.size() == 0) begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.data !== e.data) begin
                $error("cell_data exp %0h got %0h", e.data, got.data); errors++;
            end
            if (got.row !== e.row) begin
                $error("cursor_row exp %0d got %0d", e.row, got.row); errors++;
            end
            if (got.col !== e.col) begin
                $error("cursor_col exp %0d got %0d", e.col, got.col); errors++;
            end
            if (got.shown !== e.shown) begin
                $error("cursor_shown exp %0d got %0d", e.shown, got.shown); errors++;
            end
            if (got.bell !== e.bell) begin
                $error("bell_pulse exp %0d got %0d", e.bell, got.bell); errors++;
            end
        endfunction
    endclass

    logic       clk = 0;
    logic       rst_n = 0;
    logic       req_valid = 0;
    logic       req_op = 0;
    logic [7:0] req_char = 0;
    logic [4:0] req_row = 0;
    logic [6:0] req_col = 0;
    logic       out_stall = 0;
    wire        in_stall;
    wire        res_valid;
    wire  [6:0] res_cell;
    wire  [4:0] res_row;
    wire  [6:0] res_col;
    wire        res_shown;
    wire        res_bell;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_off = 0;
    int  idle_cycles = 0;
    terminal_scoreboard sb = new();

    always #5 clk = ~clk;

    text_terminal_char_engine dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(req_valid), .o_stall(in_stall),
        .i_opcode(req_op), .i_char_code(req_char),
        .i_read_row(req_row), .i_read_col(req_col),
        .o_valid(res_valid), .i_stall(out_stall),
        .o_cell_data(res_cell), .o_cursor_row(res_row), .o_cursor_col(res_col),
        .o_cursor_shown(res_shown), .o_bell_pulse(res_bell)
    );

    always @(posedge clk) begin
        if (rst_n) begin
            out_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
            if (res_valid && !out_stall)
                sb.check_result({res_cell, res_row, res_col, res_shown, res_bell});
        end
    end

    always @(posedge clk) begin
        if ((req_valid && !in_stall) || (res_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_request(bit op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            @(posedge clk);
        end
        req_valid <= 1;
        req_op    <= op;
        req_char  <= ch;
        req_row   <= rr;
        req_col   <= rc;
        do @(posedge clk); while (in_stall);
        sb.note_request(op, ch, rr, rc);
    endtask

    task automatic put(logic [7:0] ch);
        send_request(0, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(logic [4:0] rr, logic [6:0] rc);
        send_request(1, 8'($urandom), rr, rc);
    endtask

    task automatic goto_cell(int r, int c, bit use_y);
        put(ttce_pkg::CH_ESC);
        put(use_y ? ttce_pkg::CH_Y : ttce_pkg::CH_EQ);
        put(8'(r + ttce_pkg::CH_BIAS));
        put(8'(c + ttce_pkg::CH_BIAS));
    endtask

    task automatic random_request();
        int pick;
        logic [7:0] controls[19];
        controls = '{ttce_pkg::CH_HOME, ttce_pkg::CH_CUR_ON, ttce_pkg::CH_CUR_OFF,
                     ttce_pkg::CH_BELL, ttce_pkg::CH_BELL_HI, ttce_pkg::CH_BS,
                     ttce_pkg::CH_LF, ttce_pkg::CH_FF, ttce_pkg::CH_CR,
                     ttce_pkg::CH_CLR_EOS, ttce_pkg::CH_RIGHT, ttce_pkg::CH_CLR_EOL,
                     ttce_pkg::CH_INS_LN, ttce_pkg::CH_CLR_LN, ttce_pkg::CH_DEL_LN,
                     ttce_pkg::CH_UP, ttce_pkg::CH_UP_ALT, ttce_pkg::CH_DEL, 8'h00};
        pick = $urandom_range(99);
        if (pick < 30) put(8'($urandom_range(8'h7E, 8'h20)));
        else if (pick < 38) put(8'($urandom_range(8'h86, 8'h84)));
        else if (pick < 55) put(controls[$urandom_range(18)]);
        else if (pick < 65) goto_cell(int'($urandom_range(ROWS + 2)),
                                      int'($urandom_range(COLS + 2)),
                                      1'($urandom_range(1)));
        else if (pick < 70) begin
            put(ttce_pkg::CH_ESC);
            put(8'($urandom));
            if ($urandom_range(1)) put(8'($urandom));
        end else if (pick < 75) put(8'($urandom));
        else if (pick < 90) read_cell(5'($urandom_range(ROWS - 1)), 7'($urandom_range(COLS - 1)));
        else read_cell(5'($urandom), 7'($urandom));
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    initial begin
        int hold_cycles;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed part
        put(8'h41); put(8'h85); put(ttce_pkg::CH_BELL); put(ttce_pkg::CH_BELL_HI);
        put(ttce_pkg::CH_CUR_OFF);
        read_cell(5'd0, 7'd0); read_cell(5'd0, 7'd1); read_cell(5'd31, 7'd127);
        read_cell(5'd23, 7'd79);
        put(ttce_pkg::CH_CUR_ON); put(ttce_pkg::CH_BS); put(ttce_pkg::CH_DEL);
        put(ttce_pkg::CH_HOME); put(ttce_pkg::CH_BS);
        goto_cell(ROWS - 1, COLS - 1, 0);
        put(8'h7E); put(ttce_pkg::CH_LF); put(ttce_pkg::CH_RIGHT);
        put(ttce_pkg::CH_ESC); put(8'h3C);
        put(ttce_pkg::CH_ESC); put(ttce_pkg::CH_Y); put(8'hFF); put(ttce_pkg::CH_BELL);
        put(8'h00);
        req_valid <= 0;
        drain();

        // hold the receiver off while requests keep coming
        hold_off = 1;
        fork
            begin
                hold_cycles = 0;
                while (hold_cycles < 400) begin
                    @(posedge clk);
                    hold_cycles++;
                end
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 12; i++) random_request();
                req_valid <= 0;
            end
        join
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 75 : 26) : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 75 : 26) : 0;
            for (int i = 0; i < 45; i++) random_request();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 20; i++) random_request();
        req_valid <= 0;

        drain();
        repeat (2 * CELLS + 50) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end
endmodule
